// ===== hdl/rmtfq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rmtfq_pkg;

  // Queue geometry and field widths
  localparam int unsigned DEPTH_DEFAULT = 1024;
  localparam int unsigned ID_W          = 32;
  localparam int unsigned POP_W         = 11;

  // Command codes
  localparam logic CMD_SERVE    = 1'b0;
  localparam logic CMD_EXPEDITE = 1'b1;

endpackage

`default_nettype wire

// ===== hdl/rmtfq_id_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port id store: one write port, one read port, registered read.
module rmtfq_id_ram #(
  parameter int unsigned DEPTH = rmtfq_pkg::DEPTH_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]      wr_addr,
  input  wire logic [rmtfq_pkg::ID_W-1:0]    wr_data,
  input  wire logic                          rd_en,
  input  wire logic [$clog2(DEPTH)-1:0]      rd_addr,
  output logic      [rmtfq_pkg::ID_W-1:0]    rd_data
);

  logic [rmtfq_pkg::ID_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    // read data holds until the next read
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rotating_move_to_front_queue_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Serve: front id read in idle and registered in ST_SERVE; next command taken back in idle.
// Expedite: one id store read per entry scanned; for a hit at position h, the h entries ahead
//   shift back by one, then the id is written at the front; insert ends with the scan.
// Reset / population write: load of ids 1..min(population, DEPTH) (id 1 after reset) through
//   the single write port; no input transaction taken meanwhile.
module rotating_move_to_front_queue_unit #(
  parameter int unsigned DEPTH = rmtfq_pkg::DEPTH_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // configuration write channel (population)
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [rmtfq_pkg::POP_W-1:0]     population,
  // command channel
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            command,
  input  wire logic [rmtfq_pkg::ID_W-1:0]      target_id,
  // result channel
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic      [rmtfq_pkg::ID_W-1:0]      served_id,
  output logic                                 overflow
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);

  // One-hot control states
  typedef enum logic [6:0] {
    ST_LOAD   = 7'b0000001,  // fill ids 1..count
    ST_IDLE   = 7'b0000010,
    ST_SERVE  = 7'b0000100,  // front id arrives from the store
    ST_SEARCH = 7'b0001000,  // compare one entry per cycle
    ST_SHIFT  = 7'b0010000,  // move entries ahead of the hit back by one
    ST_PUT    = 7'b0100000,  // write the expedited id at the front
    ST_OVF    = 7'b1000000   // report a dropped insert
  } state_t;

  state_t state, state_next;

  logic [AW-1:0]              front, front_next;
  logic [CW-1:0]              count, count_next;
  // load position, scan position or shift destination, by state
  logic [CW-1:0]              idx, idx_next;
  logic [rmtfq_pkg::ID_W-1:0] target, target_next;

  logic                       out_valid_next;
  logic [rmtfq_pkg::ID_W-1:0] served_id_next;
  logic                       overflow_next;
  logic                       out_free;

  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  logic [rmtfq_pkg::ID_W-1:0] wr_data;
  logic                       rd_en;
  logic [AW-1:0]              rd_addr;
  logic [rmtfq_pkg::ID_W-1:0] rd_data;

  logic [CW-1:0]              pop_cap;
  logic [AW-1:0]              front_prev;

  // physical address of the entry at offset off from the front; off <= DEPTH
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] base,
                                         input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(off);
    if (sum >= (CW+1)'(DEPTH)) begin
      sum = sum - (CW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  rmtfq_id_ram #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Config only lands while idle; it wins over a command in the same cycle.
  assign cfg_ready = (state == ST_IDLE);
  assign in_ready  = (state == ST_IDLE) && !cfg_valid;
  // result register frees up in the same cycle it is taken
  assign out_free  = !out_valid || out_ready;

  assign pop_cap    = (32'(population) < 32'(DEPTH)) ? CW'(population) : DEPTH_C;
  assign front_prev = (front == '0) ? LAST_A : front - AW'(1);

  always_comb begin
    state_next     = state;
    front_next     = front;
    count_next     = count;
    idx_next       = idx;
    target_next    = target;
    out_valid_next = out_valid && !out_ready;
    served_id_next = served_id;
    overflow_next  = overflow;
    wr_en          = 1'b0;
    wr_addr        = front;
    wr_data        = target;
    rd_en          = 1'b0;
    rd_addr        = front;

    case (state)
      ST_LOAD: begin
        wr_en    = 1'b1;
        wr_addr  = idx[AW-1:0];
        wr_data  = rmtfq_pkg::ID_W'(idx) + rmtfq_pkg::ID_W'(1);
        idx_next = idx + CW'(1);
        if (idx + CW'(1) == count) begin
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (cfg_valid) begin
          count_next = pop_cap;
          front_next = '0;
          idx_next   = '0;
          state_next = (pop_cap == '0) ? ST_IDLE : ST_LOAD;
        end else if (in_valid) begin
          target_next = target_id;
          if (command == rmtfq_pkg::CMD_SERVE) begin
            // empty queue: no result, nothing changes
            if (count != '0) begin
              rd_en      = 1'b1;
              rd_addr    = front;
              state_next = ST_SERVE;
            end
          end else if (count == '0) begin
            // nothing to search: insert at once
            wr_en      = 1'b1;
            wr_addr    = front_prev;
            wr_data    = target_id;
            front_next = front_prev;
            count_next = count + CW'(1);
          end else begin
            rd_en      = 1'b1;
            rd_addr    = front;
            idx_next   = '0;
            state_next = ST_SEARCH;
          end
        end
      end

      ST_SERVE: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          served_id_next = rd_data;
          overflow_next  = 1'b0;
          // rotate: front id goes behind the last entry
          if (count > CW'(1)) begin
            wr_en      = 1'b1;
            wr_addr    = slot(front, count);
            wr_data    = rd_data;
            front_next = slot(front, CW'(1));
          end
          state_next = ST_IDLE;
        end
      end

      ST_SEARCH: begin
        if (rd_data == target) begin
          if (idx == '0) begin
            // already at the front
            state_next = ST_IDLE;
          end else begin
            rd_en      = 1'b1;
            rd_addr    = slot(front, idx - CW'(1));
            state_next = ST_SHIFT;
          end
        end else if (idx == count - CW'(1)) begin
          if (count == DEPTH_C) begin
            state_next = ST_OVF;
          end else begin
            wr_en      = 1'b1;
            wr_addr    = front_prev;
            wr_data    = target;
            front_next = front_prev;
            count_next = count + CW'(1);
            state_next = ST_IDLE;
          end
        end else begin
          rd_en    = 1'b1;
          rd_addr  = slot(front, idx + CW'(1));
          idx_next = idx + CW'(1);
        end
      end

      ST_SHIFT: begin
        // entry idx-1 arrived; it moves to idx, next read is two below idx
        wr_en   = 1'b1;
        wr_addr = slot(front, idx);
        wr_data = rd_data;
        if (idx == CW'(1)) begin
          state_next = ST_PUT;
        end else begin
          rd_en    = 1'b1;
          rd_addr  = slot(front, idx - CW'(2));
          idx_next = idx - CW'(1);
        end
      end

      ST_PUT: begin
        wr_en      = 1'b1;
        wr_addr    = front;
        wr_data    = target;
        state_next = ST_IDLE;
      end

      ST_OVF: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          served_id_next = '0;
          overflow_next  = 1'b1;
          state_next     = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      // reset population is one: load id 1 at entry 0
      state     <= ST_LOAD;
      front     <= '0;
      count     <= CW'(1);
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      front     <= front_next;
      count     <= count_next;
      idx       <= idx_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    target    <= target_next;
    served_id <= served_id_next;
    overflow  <= overflow_next;
  end

endmodule

`default_nettype wire
